[rtl/core/keyed_scan_cache_oldest_evict_defines.svh]
// Assertion macros for the keyed sighting cache.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef KEYED_SCAN_CACHE_OLDEST_EVICT_DEFINES_SVH
`define KEYED_SCAN_CACHE_OLDEST_EVICT_DEFINES_SVH
`ifndef SYNTHESIS
`define KSCO_ASSERT_IMPLY(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("ksco check failed");
`define KSCO_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("ksco check failed");
`else
`define KSCO_ASSERT_IMPLY(lbl, clk, rst, a, b)
`define KSCO_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

[rtl/core/ksco_pkg.sv]
// Shared widths, codes and types of the keyed sighting cache.
// No dependencies; used by ksco_cell and the top level.
package ksco_pkg;
   localparam int ADDR_W    = 48;
   localparam int STAMP_W   = 32;
   localparam int DBM_W     = 8;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int DEFAULT_ENTRIES = 32;

   localparam logic [STAMP_W-1:0] STALE_LIMIT_RESET = 32'd10000;
   localparam logic [DBM_W-1:0]   DBM_NONE = 8'h80;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_REFRESH = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FILL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIT     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STALE   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISS    = 3'd5;

   // query and running scan results passed cell to cell
   typedef struct packed {
      logic               active;
      logic               cmd;
      logic [ADDR_W-1:0]  addr;
      logic               kind;
      logic [DBM_W-1:0]   dbm;
      logic [STAMP_W-1:0] now;
      logic               match_hit;
      logic [DBM_W-1:0]   match_dbm;
      logic [STAMP_W-1:0] match_stamp;
      logic               free_hit;
      logic [STAMP_W-1:0] best_stamp;
   } probe_type;

   // entry write broadcast to every cell
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic               kind;
      logic [DBM_W-1:0]   dbm;
      logic [STAMP_W-1:0] stamp;
   } wr_type;
endpackage

[rtl/core/ksco_cell.sv]
// One cache entry plus one registered scan stage of the cell chain.
// Depends on ksco_pkg.
module ksco_cell #(
   parameter int IDX_W    = 5,
   parameter int CELL_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  ksco_pkg::probe_type up_scan,
   input  logic [IDX_W-1:0]    up_match_idx,
   input  logic [IDX_W-1:0]    up_free_idx,
   input  logic [IDX_W-1:0]    up_best_idx,
   output ksco_pkg::probe_type dn_scan,
   output logic [IDX_W-1:0]    dn_match_idx,
   output logic [IDX_W-1:0]    dn_free_idx,
   output logic [IDX_W-1:0]    dn_best_idx,
   input  ksco_pkg::wr_type    wr,
   input  logic [IDX_W-1:0]    wr_idx
);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                          valid_ff;
   logic [ksco_pkg::ADDR_W-1:0]   addr_ff;
   logic                          kind_ff;
   logic [ksco_pkg::DBM_W-1:0]    dbm_ff;
   logic [ksco_pkg::STAMP_W-1:0]  stamp_ff;

   ksco_pkg::probe_type scan_ff, scan_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic hit_here;

   assign hit_here = valid_ff && (kind_ff == up_scan.kind) && (addr_ff == up_scan.addr);

   always_comb begin
      scan_in      = up_scan;
      match_idx_in = up_match_idx;
      free_idx_in  = up_free_idx;
      best_idx_in  = up_best_idx;
      if (!up_scan.match_hit && hit_here) begin
         scan_in.match_hit   = 1'b1;
         scan_in.match_dbm   = dbm_ff;
         scan_in.match_stamp = stamp_ff;
         match_idx_in        = MY_IDX;
      end
      if (!up_scan.free_hit && !valid_ff) begin
         scan_in.free_hit = 1'b1;
         free_idx_in      = MY_IDX;
      end
      if (stamp_ff < up_scan.best_stamp) begin
         scan_in.best_stamp = stamp_ff;
         best_idx_in        = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.active <= 1'b0;
      end else begin
         scan_ff.active <= scan_in.active;
      end
      scan_ff.cmd         <= scan_in.cmd;
      scan_ff.addr        <= scan_in.addr;
      scan_ff.kind        <= scan_in.kind;
      scan_ff.dbm         <= scan_in.dbm;
      scan_ff.now         <= scan_in.now;
      scan_ff.match_hit   <= scan_in.match_hit;
      scan_ff.match_dbm   <= scan_in.match_dbm;
      scan_ff.match_stamp <= scan_in.match_stamp;
      scan_ff.free_hit    <= scan_in.free_hit;
      scan_ff.best_stamp  <= scan_in.best_stamp;
      match_idx_ff        <= match_idx_in;
      free_idx_ff         <= free_idx_in;
      best_idx_ff         <= best_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && (wr_idx == MY_IDX)) begin
         valid_ff <= 1'b1;
      end
      if (wr.en && (wr_idx == MY_IDX)) begin
         addr_ff  <= wr.addr;
         kind_ff  <= wr.kind;
         dbm_ff   <= wr.dbm;
         stamp_ff <= wr.stamp;
      end
   end

   assign dn_scan      = scan_ff;
   assign dn_match_idx = match_idx_ff;
   assign dn_free_idx  = free_idx_ff;
   assign dn_best_idx  = best_idx_ff;
endmodule

[rtl/core/keyed_scan_cache_oldest_evict.sv]
// Top level of the keyed sighting cache: request/response streams, the
// cell chain, result selection and the stale limit register.
// Depends on ksco_pkg, ksco_cell and keyed_scan_cache_oldest_evict_defines.svh.
//
// Usage:
//   req_*  : one command per transfer. cmd in tuser[0] selects update (0)
//            or lookup (1); tuser[1] is the device kind.
//   rsp_*  : exactly one result per command, in command order.
//   csr_*  : write of stale_limit_ms, taken whenever csr_wr_en is high;
//            write it only while no command is outstanding.
// Each command walks the chain of ENTRIES cells, one cell per cycle, then
// the chosen entry is written and the result is registered. A new command
// is taken only after the previous result has left the holding register
// for rsp_*, so only one command is in the chain or waiting at a time;
// the pace is set by the length of the cell chain.
// If the receiver stalls, the result holds in rsp_*, the next command may
// still be taken and scanned, and it waits in a holding register until
// the output is free; req_tready stays low meanwhile.
// Reset clears every entry valid bit at once, clears all outstanding work
// and loads stale_limit_ms with 10000; no clearing pass is needed.
module keyed_scan_cache_oldest_evict #(
   parameter int ENTRIES = ksco_pkg::DEFAULT_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // dev_addr[47:0], signal_dbm[55:48], now_ms[87:56]
   input  logic [1:0]   req_tuser,   // cmd[0], dev_kind[1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // slot[4:0], found_dbm[12:5], zero[15:13]
   output logic [2:0]   rsp_tuser,   // status[2:0]
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);
   `include "keyed_scan_cache_oldest_evict_defines.svh"

   localparam int IDX_W = $clog2(ENTRIES);

   ksco_pkg::probe_type stage [ENTRIES+1];
   logic [IDX_W-1:0] match_idx [ENTRIES+1];
   logic [IDX_W-1:0] free_idx  [ENTRIES+1];
   logic [IDX_W-1:0] best_idx  [ENTRIES+1];
   logic [ENTRIES:0] act_vec;

   ksco_pkg::wr_type wr;
   logic [IDX_W-1:0] wr_idx;

   logic                           accept;
   logic                           busy_ff, busy_in;
   logic                           pend_ff, pend_in;
   logic                           move;
   logic [ksco_pkg::STAMP_W-1:0]   limit_ff;
   logic [ksco_pkg::STATUS_W-1:0]  res_status;
   logic [IDX_W-1:0]               res_idx;
   logic [ksco_pkg::DBM_W-1:0]     res_dbm;
   logic [ksco_pkg::STAMP_W-1:0]   age;
   logic [ksco_pkg::STATUS_W-1:0]  pend_status_ff, rsp_status_ff;
   logic [ksco_pkg::SLOT_W-1:0]    pend_slot_ff, rsp_slot_ff;
   logic [ksco_pkg::DBM_W-1:0]     pend_dbm_ff, rsp_dbm_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   ksco_pkg::probe_type            tail;

   assign accept     = req_tvalid && !busy_ff;
   assign req_tready = !busy_ff;

   always_comb begin
      stage[0].active      = accept;
      stage[0].cmd         = req_tuser[0];
      stage[0].kind        = req_tuser[1];
      stage[0].addr        = req_tdata[47:0];
      stage[0].dbm         = req_tdata[55:48];
      stage[0].now         = req_tdata[87:56];
      stage[0].match_hit   = 1'b0;
      stage[0].match_dbm   = ksco_pkg::DBM_NONE;
      stage[0].match_stamp = '0;
      stage[0].free_hit    = 1'b0;
      stage[0].best_stamp  = req_tdata[87:56];
      match_idx[0]         = '0;
      free_idx[0]          = '0;
      best_idx[0]          = '0;
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      ksco_cell #(.IDX_W(IDX_W), .CELL_IDX(i)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .up_scan      (stage[i]),
         .up_match_idx (match_idx[i]),
         .up_free_idx  (free_idx[i]),
         .up_best_idx  (best_idx[i]),
         .dn_scan      (stage[i+1]),
         .dn_match_idx (match_idx[i+1]),
         .dn_free_idx  (free_idx[i+1]),
         .dn_best_idx  (best_idx[i+1]),
         .wr           (wr),
         .wr_idx       (wr_idx)
      );
      assign act_vec[i] = stage[i+1].active;
   end
   assign act_vec[ENTRIES] = pend_ff;

   assign tail = stage[ENTRIES];
   assign age  = tail.now - tail.match_stamp;

   always_comb begin
      res_dbm = ksco_pkg::DBM_NONE;
      res_idx = '0;
      if (tail.cmd == ksco_pkg::CMD_UPDATE) begin
         if (tail.match_hit) begin
            res_status = ksco_pkg::ST_REFRESH;
            res_idx    = match_idx[ENTRIES];
         end else if (tail.free_hit) begin
            res_status = ksco_pkg::ST_FILL;
            res_idx    = free_idx[ENTRIES];
         end else begin
            res_status = ksco_pkg::ST_EVICT;
            res_idx    = best_idx[ENTRIES];
         end
      end else if (!tail.match_hit) begin
         res_status = ksco_pkg::ST_MISS;
      end else if (age > limit_ff) begin
         res_status = ksco_pkg::ST_STALE;
         res_idx    = match_idx[ENTRIES];
      end else begin
         res_status = ksco_pkg::ST_HIT;
         res_idx    = match_idx[ENTRIES];
         res_dbm    = tail.match_dbm;
      end
   end

   assign wr.en    = tail.active && (tail.cmd == ksco_pkg::CMD_UPDATE);
   assign wr.addr  = tail.addr;
   assign wr.kind  = tail.kind;
   assign wr.dbm   = tail.dbm;
   assign wr.stamp = tail.now;
   assign wr_idx   = res_idx;

   assign move = pend_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end
      pend_in = pend_ff;
      if (tail.active) begin
         pend_in = 1'b1;
      end else if (move) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= ksco_pkg::STALE_LIMIT_RESET;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
      if (tail.active) begin
         pend_status_ff <= res_status;
         pend_slot_ff   <= ksco_pkg::SLOT_W'(res_idx);
         pend_dbm_ff    <= res_dbm;
      end
      if (move) begin
         rsp_status_ff <= pend_status_ff;
         rsp_slot_ff   <= pend_slot_ff;
         rsp_dbm_ff    <= pend_dbm_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_dbm_ff, rsp_slot_ff};

   `KSCO_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `KSCO_ASSERT_IMPLY(a_one_in_flight, clock, reset, 1'b1, $onehot0(act_vec))
   `KSCO_ASSERT_NEXT(a_tail_to_pend, clock, reset, tail.active, pend_ff)
   `KSCO_ASSERT_IMPLY(a_idle_empty, clock, reset, !busy_ff, act_vec == '0)
endmodule

[sim/keyed_scan_cache_oldest_evict_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for keyed_scan_cache_oldest_evict: directed and random
// update/lookup traffic with stream back-pressure, checked against a local table model.
// Depends on ksco_pkg and the keyed_scan_cache_oldest_evict RTL.
module keyed_scan_cache_oldest_evict_tb;
   localparam int N_ENTRIES      = 32;
   localparam int POOL_SIZE      = 40;
   localparam int DRAIN_CYCLES   = N_ENTRIES + 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 210;

   typedef struct packed {
      logic                         cmd;
      logic [ksco_pkg::ADDR_W-1:0]  addr;
      logic                         kind;
      logic [ksco_pkg::DBM_W-1:0]   dbm;
      logic [ksco_pkg::STAMP_W-1:0] now;
   } sighting_type;

   typedef struct packed {
      logic [ksco_pkg::STATUS_W-1:0] status;
      logic [ksco_pkg::SLOT_W-1:0]   slot;
      logic [ksco_pkg::DBM_W-1:0]    dbm;
   } verdict_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [87:0]  req_tdata;   // dev_addr[47:0], signal_dbm[55:48], now_ms[87:56]
   logic [1:0]   req_tuser;   // cmd[0], dev_kind[1]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;   // slot[4:0], found_dbm[12:5], zero[15:13]
   logic [2:0]   rsp_tuser;   // status[2:0]
   logic         csr_wr_en;
   logic [31:0]  csr_wr_data;

   // local copy of the table and the stale limit
   logic                         tbl_valid [N_ENTRIES];
   logic [ksco_pkg::ADDR_W-1:0]  tbl_addr  [N_ENTRIES];
   logic                         tbl_kind  [N_ENTRIES];
   logic [ksco_pkg::DBM_W-1:0]   tbl_dbm   [N_ENTRIES];
   logic [ksco_pkg::STAMP_W-1:0] tbl_stamp [N_ENTRIES];
   logic [ksco_pkg::STAMP_W-1:0] stale_limit;

   verdict_type                  pending_verdicts[$];
   verdict_type                  want;
   int                           errors = 0;
   int                           idle_cycles = 0;
   logic                         calm = 1'b0;
   logic [ksco_pkg::STAMP_W-1:0] air_time = '0;
   logic [ksco_pkg::ADDR_W-1:0]  addr_pool [POOL_SIZE];

   keyed_scan_cache_oldest_evict DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 120);
   endfunction

   function automatic sighting_type make_sighting(
      input logic                         c,
      input logic [ksco_pkg::ADDR_W-1:0]  a,
      input logic                         k,
      input logic [ksco_pkg::DBM_W-1:0]   d,
      input logic [ksco_pkg::STAMP_W-1:0] t);
      sighting_type s;
      s.cmd  = c;
      s.addr = a;
      s.kind = k;
      s.dbm  = d;
      s.now  = t;
      return s;
   endfunction

   // applies one command to the local table and returns the result it gives
   function automatic verdict_type predict_sighting(input sighting_type s);
      verdict_type                  v;
      int                           idx;
      int                           i;
      logic [ksco_pkg::STAMP_W-1:0] best;
      logic [ksco_pkg::STAMP_W-1:0] age;
      v.status = ksco_pkg::ST_MISS;
      v.slot   = '0;
      v.dbm    = ksco_pkg::DBM_NONE;
      idx      = -1;
      for (i = 0; i < N_ENTRIES; i++)
         if (idx < 0 && tbl_valid[i] && tbl_kind[i] == s.kind && tbl_addr[i] == s.addr)
            idx = i;
      if (s.cmd == ksco_pkg::CMD_UPDATE) begin
         if (idx >= 0) begin
            v.status = ksco_pkg::ST_REFRESH;
         end else begin
            for (i = 0; i < N_ENTRIES; i++)
               if (idx < 0 && !tbl_valid[i]) idx = i;
            if (idx >= 0) begin
               v.status = ksco_pkg::ST_FILL;
            end else begin
               // plain unsigned compare; nothing older than now falls back to slot 0
               best = s.now;
               idx  = 0;
               for (i = 0; i < N_ENTRIES; i++) begin
                  if (tbl_stamp[i] < best) begin
                     best = tbl_stamp[i];
                     idx  = i;
                  end
               end
               v.status = ksco_pkg::ST_EVICT;
            end
         end
         tbl_valid[idx] = 1'b1;
         tbl_addr[idx]  = s.addr;
         tbl_kind[idx]  = s.kind;
         tbl_dbm[idx]   = s.dbm;
         tbl_stamp[idx] = s.now;
         v.slot = idx[ksco_pkg::SLOT_W-1:0];
      end else if (idx >= 0) begin
         v.slot = idx[ksco_pkg::SLOT_W-1:0];
         age    = s.now - tbl_stamp[idx];
         if (age > stale_limit) begin
            v.status = ksco_pkg::ST_STALE;
         end else begin
            v.status = ksco_pkg::ST_HIT;
            v.dbm    = tbl_dbm[idx];
         end
      end
      return v;
   endfunction

   task automatic send_item(input sighting_type s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.now, s.dbm, s.addr};
      req_tuser  <= {s.kind, s.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(predict_sighting(s));
   endtask

   task automatic drain_stream();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_stale_limit(input logic [31:0] value);
      drain_stream();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      stale_limit = value;
   endtask

   // empty table, fills, refresh, fresh/stale boundary and wrapping age
   task automatic test_lookup_basics();
      logic [ksco_pkg::ADDR_W-1:0] a;
      logic [ksco_pkg::ADDR_W-1:0] ones;
      logic                        upd;
      logic                        lkp;
      a    = 48'hA5C3_1E0F_7B92;
      ones = '1;
      upd  = ksco_pkg::CMD_UPDATE;
      lkp  = ksco_pkg::CMD_LOOKUP;
      send_item(make_sighting(lkp, a,    1'b0, 8'h00, 32'd500));
      send_item(make_sighting(upd, a,    1'b0, 8'h7F, 32'd1000));
      send_item(make_sighting(upd, a,    1'b1, 8'h80, 32'd1000));
      send_item(make_sighting(upd, '0,   1'b0, 8'h00, 32'd0));
      send_item(make_sighting(upd, ones, 1'b1, 8'hFF, 32'hFFFF_FFFF));
      send_item(make_sighting(lkp, a,    1'b0, 8'h00, 32'd11000));
      send_item(make_sighting(lkp, a,    1'b0, 8'h00, 32'd11001));
      send_item(make_sighting(upd, a,    1'b0, 8'h05, 32'd20000));
      send_item(make_sighting(lkp, a,    1'b0, 8'hFF, 32'd20000));
      send_item(make_sighting(lkp, a,    1'b1, 8'h00, 32'd16));
      send_item(make_sighting(lkp, ones, 1'b1, 8'h00, 32'd9));
      send_item(make_sighting(lkp, '0,   1'b1, 8'h00, 32'd0));
      send_item(make_sighting(lkp, '0,   1'b0, 8'h00, 32'd10000));
   endtask

   task automatic test_limit_extremes();
      logic [ksco_pkg::ADDR_W-1:0] a;
      logic                        lkp;
      a   = 48'hA5C3_1E0F_7B92;
      lkp = ksco_pkg::CMD_LOOKUP;
      write_stale_limit(32'd0);
      send_item(make_sighting(lkp, a,  1'b0, 8'h00, 32'd20000));
      send_item(make_sighting(lkp, a,  1'b0, 8'h00, 32'd20001));
      write_stale_limit(32'hFFFF_FFFF);
      send_item(make_sighting(lkp, a,  1'b1, 8'h00, 32'd16));
      send_item(make_sighting(lkp, '0, 1'b0, 8'h00, 32'hFFFF_FFFF));
   endtask

   // keys mostly from a pool larger than the table, so refreshes, hits and
   // evictions all occur; time mostly advances, sometimes jumps or goes back
   task automatic test_random_traffic(input logic [31:0] limit_value, input int count);
      sighting_type s;
      int           n;
      int           r;
      logic [63:0]  wide;
      logic [31:0]  word;
      write_stale_limit(limit_value);
      for (n = 0; n < count; n++) begin
         if (n % 50 == 0) calm = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 99);
         if (r < 20) begin
         end else if (r < 72) begin
            air_time += $urandom_range(1, 3000);
         end else if (r < 86) begin
            air_time += $urandom_range(3000, 40000);
         end else if (r < 92) begin
            air_time = $urandom;
         end else if (r < 98) begin
            air_time -= $urandom_range(1, 50000);
         end else if (r == 98) begin
            air_time = '0;
         end else begin
            air_time = '1;
         end
         wide = {$urandom, $urandom};
         word = $urandom;
         s.cmd  = ($urandom_range(0, 1) == 0) ? ksco_pkg::CMD_UPDATE : ksco_pkg::CMD_LOOKUP;
         s.addr = ($urandom_range(0, 9) == 0) ? wide[ksco_pkg::ADDR_W-1:0]
                                              : addr_pool[$urandom_range(0, POOL_SIZE-1)];
         s.kind = word[8];
         s.dbm  = word[ksco_pkg::DBM_W-1:0];
         s.now  = air_time;
         send_item(s);
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual status %0d slot %0d dbm %h",
                     $time, rsp_tuser, rsp_tdata[4:0], rsp_tdata[12:5]);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tuser !== want.status) begin
               errors++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_tuser);
            end
            if (rsp_tdata[4:0] !== want.slot) begin
               errors++;
               $display("%0t: slot mismatch, expected %0d, actual %0d",
                        $time, want.slot, rsp_tdata[4:0]);
            end
            if (rsp_tdata[12:5] !== want.dbm) begin
               errors++;
               $display("%0t: found_dbm mismatch, expected %h, actual %h",
                        $time, want.dbm, rsp_tdata[12:5]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, pending_verdicts.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : rsp_stall
      int hold;
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         hold = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (hold) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin : main
      int i;
      logic [63:0] wide;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      stale_limit = ksco_pkg::STALE_LIMIT_RESET;
      for (i = 0; i < N_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_addr[i]  = '0;
         tbl_kind[i]  = 1'b0;
         tbl_dbm[i]   = '0;
         tbl_stamp[i] = '0;
      end
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (i = 2; i < POOL_SIZE; i++) begin
         wide = {$urandom, $urandom};
         addr_pool[i] = wide[ksco_pkg::ADDR_W-1:0];
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_lookup_basics();
      test_limit_extremes();
      test_random_traffic(ksco_pkg::STALE_LIMIT_RESET, RANDOM_ITEMS);
      test_random_traffic($urandom, RANDOM_ITEMS);
      test_random_traffic(32'd0, RANDOM_ITEMS);
      test_random_traffic(32'd2500, RANDOM_ITEMS);
      test_random_traffic(32'hFFFF_FFFF, RANDOM_ITEMS);
      drain_stream();

      if (errors == 0 && pending_verdicts.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ksco_pkg.sv
rtl/core/ksco_cell.sv
rtl/core/keyed_scan_cache_oldest_evict.sv
sim/keyed_scan_cache_oldest_evict_tb.sv
